FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the compensation unit.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while reset is asserted.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication check.
`define CHK_IMPLY(lbl, ante, cons, msg) \
  `CHK_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

FILE: rtl/core/bpc_pkg.sv
// Shared constants for the barometric pressure and temperature compensation unit.
// No dependencies.
package bpc_pkg;

  // Calibration register indexes.
  localparam logic [2:0] IDX_C1    = 3'd0;
  localparam logic [2:0] IDX_C2    = 3'd1;
  localparam logic [2:0] IDX_C3    = 3'd2;
  localparam logic [2:0] IDX_C4    = 3'd3;
  localparam logic [2:0] IDX_C5    = 3'd4;
  localparam logic [2:0] IDX_C6    = 3'd5;
  localparam int         NUM_CALIB = 6;

  localparam int CALIB_W = 16;
  localparam int RAW_W   = 24;
  localparam int TEMP_W  = 19;
  localparam int PRES_W  = 32;

  // Pipeline depth.
  localparam int NUM_STG = 10;

  // 20.00 C in hundredths of a degree.
  localparam logic signed [19:0] TEMP_REF = 20'sd2000;

  localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

endpackage

FILE: rtl/core/baro_pressure_temp_compensation_unit.sv
// Compensation datapath: raw pressure and temperature words in, temperature and pressure out.
// Depends on bpc_pkg and assert_macros.svh.
//
// The unit takes one word per cycle while the input side is not held off and carries it through the
// ten register stages of the datapath, of which the pressure multiply takes two (the 24 x 38 bit
// product is split into two partial products), and delivers its result from the last stage.
// Each stage holds its word until the next stage is free, so a stall on the output side fills
// the empty stages before the input side is held off. Calibration words are written through
// the cfg port and must only change while no word is in flight.
`include "assert_macros.svh"

module baro_pressure_temp_compensation_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [18:0] temperature_centi, [50:19] pressure_pa, rest zero
);

  localparam int NS = bpc_pkg::NUM_STG;

  logic [bpc_pkg::CALIB_W-1:0] calib_r [bpc_pkg::NUM_CALIB];
  logic [NS-1:0] vld_r, vld_nxt, en;

  logic [15:0] c1, c2, c3, c4, c5, c6;
  assign c1 = calib_r[bpc_pkg::IDX_C1];
  assign c2 = calib_r[bpc_pkg::IDX_C2];
  assign c3 = calib_r[bpc_pkg::IDX_C3];
  assign c4 = calib_r[bpc_pkg::IDX_C4];
  assign c5 = calib_r[bpc_pkg::IDX_C5];
  assign c6 = calib_r[bpc_pkg::IDX_C6];

  // Stage 0: temperature difference.
  logic [23:0]        d1_0_r;
  logic signed [24:0] dt_0_r, dt_0_nxt;
  // Stage 1: products with dT.
  logic [23:0]        d1_1_r;
  logic signed [41:0] m6_1_r, m4_1_r, m3_1_r, m6_1_nxt, m4_1_nxt, m3_1_nxt;
  logic [47:0]        sq_1_r, sq_1_nxt;
  logic signed [24:0] adt_full;
  // Stage 2: first-order terms.
  logic [23:0]        d1_2_r;
  logic signed [19:0] temp1_2_r, temp1_2_nxt;
  logic signed [35:0] off1_2_r, off1_2_nxt;
  logic signed [34:0] sens1_2_r, sens1_2_nxt;
  logic [16:0]        t2_2_r;
  logic [17:0]        dtemp_2_r, dtemp_2_nxt;
  logic               low_2_r;
  logic signed [41:0] m6b, m4b, m3b;
  logic [18:0]        q6;
  logic signed [19:0] neg_q6;
  // Stage 3: second-order terms.
  logic [23:0]        d1_3_r;
  logic signed [19:0] temp_3_r, temp_3_nxt;
  logic signed [35:0] off1_3_r;
  logic signed [34:0] sens1_3_r;
  logic [36:0]        aux5_3_r, aux5_3_nxt;
  logic               low_3_r;
  logic [20:0]        dtemp5;
  logic [38:0]        aux5_full;
  // Stage 4: corrected offset and sensitivity, saturated temperature.
  logic [23:0]        d1_4_r;
  logic signed [18:0] temp_4_r, temp_4_nxt;
  logic signed [38:0] off_4_r, off_4_nxt;
  logic signed [37:0] sens_4_r, sens_4_nxt;
  // Stage 5: partial products of D1 * SENS.
  logic signed [18:0] temp_5_r;
  logic signed [38:0] off_5_r;
  logic [42:0]        pl_5_r, pl_5_nxt;
  logic signed [43:0] ph_5_r, ph_5_nxt;
  // Stage 6: full product.
  logic signed [18:0] temp_6_r;
  logic signed [38:0] off_6_r;
  logic signed [63:0] prod_6_r, prod_6_nxt;
  // Stage 7: product / 2^21.
  logic signed [18:0] temp_7_r;
  logic signed [38:0] off_7_r;
  logic signed [42:0] q_7_r;
  logic signed [63:0] prodb;
  // Stage 8: minus offset.
  logic signed [18:0] temp_8_r;
  logic signed [43:0] b_8_r, b_8_nxt;
  // Stage 9: / 2^15, output register.
  logic signed [18:0] temp_9_r;
  logic signed [31:0] pres_9_r, pres_9_nxt;
  logic signed [43:0] bb;

  // Ready chain: a stage may load when it is empty or its word moves on.
  always_comb begin
    en[NS-1] = !vld_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
    vld_nxt[0] = en[0] ? in_tvalid : vld_r[0];
    for (int i = 1; i < NS; i++) begin
      vld_nxt[i] = en[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = {5'd0, pres_9_r, temp_9_r};

  always_comb begin
    dt_0_nxt = $signed({1'b0, in_tdata[47:24]}) - $signed({1'b0, c5, 8'd0});

    m6_1_nxt = dt_0_r * $signed({1'b0, c6});
    m4_1_nxt = dt_0_r * $signed({1'b0, c4});
    m3_1_nxt = dt_0_r * $signed({1'b0, c3});
    adt_full = dt_0_r[24] ? -dt_0_r : dt_0_r;
    sq_1_nxt = {24'd0, adt_full[23:0]} * {24'd0, adt_full[23:0]};

    // Adding (2^k - 1) to negative values before the shift truncates toward zero.
    m6b = m6_1_r + $signed({19'd0, {23{m6_1_r[41]}}});
    m4b = m4_1_r + $signed({35'd0, {7{m4_1_r[41]}}});
    m3b = m3_1_r + $signed({34'd0, {8{m3_1_r[41]}}});
    q6  = m6b[41:23];
    temp1_2_nxt = $signed({q6[18], q6}) + bpc_pkg::TEMP_REF;
    off1_2_nxt  = $signed({4'd0, c2, 16'd0}) + $signed({m4b[41], m4b[41:7]});
    sens1_2_nxt = $signed({4'd0, c1, 15'd0}) + $signed({m3b[41], m3b[41:8]});
    // The temperature is below 20.00 C exactly when dT*C6/2^23 is negative.
    neg_q6      = -$signed({q6[18], q6});
    dtemp_2_nxt = neg_q6[17:0];

    dtemp5     = {3'd0, dtemp_2_r} * 21'd5;
    aux5_full  = {21'd0, dtemp_2_r} * {18'd0, dtemp5};
    aux5_3_nxt = low_2_r ? aux5_full[36:0] : '0;
    temp_3_nxt = low_2_r ? temp1_2_r - $signed({3'd0, t2_2_r}) : temp1_2_r;

    if (temp_3_r[19] != temp_3_r[18]) begin
      temp_4_nxt = temp_3_r[19] ? bpc_pkg::TEMP_MIN : bpc_pkg::TEMP_MAX;
    end else begin
      temp_4_nxt = temp_3_r[18:0];
    end
    off_4_nxt  = {{3{off1_3_r[35]}}, off1_3_r} - {3'd0, aux5_3_r[36:1]};
    sens_4_nxt = {{3{sens1_3_r[34]}}, sens1_3_r} - {3'd0, aux5_3_r[36:2]};

    pl_5_nxt = {19'd0, d1_4_r} * {24'd0, sens_4_r[18:0]};
    ph_5_nxt = $signed({1'b0, d1_4_r}) * $signed(sens_4_r[37:19]);

    prod_6_nxt = $signed({ph_5_r[43], ph_5_r, 19'd0}) + $signed({21'd0, pl_5_r});

    prodb = prod_6_r + $signed({43'd0, {21{prod_6_r[63]}}});

    b_8_nxt = $signed({q_7_r[42], q_7_r}) - $signed({{5{off_7_r[38]}}, off_7_r});

    // The 29-bit quotient always fits the 32-bit result.
    bb         = b_8_r + $signed({29'd0, {15{b_8_r[43]}}});
    pres_9_nxt = $signed({{3{bb[43]}}, bb[43:15]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      for (int i = 0; i < bpc_pkg::NUM_CALIB; i++) begin
        calib_r[i] <= '0;
      end
    end else begin
      vld_r <= vld_nxt;
      if (cfg_we && (cfg_index < 3'(bpc_pkg::NUM_CALIB))) begin
        calib_r[cfg_index] <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_0_r <= in_tdata[23:0];
      dt_0_r <= dt_0_nxt;
    end
    if (en[1]) begin
      d1_1_r <= d1_0_r;
      m6_1_r <= m6_1_nxt;
      m4_1_r <= m4_1_nxt;
      m3_1_r <= m3_1_nxt;
      sq_1_r <= sq_1_nxt;
    end
    if (en[2]) begin
      d1_2_r    <= d1_1_r;
      temp1_2_r <= temp1_2_nxt;
      off1_2_r  <= off1_2_nxt;
      sens1_2_r <= sens1_2_nxt;
      t2_2_r    <= sq_1_r[47:31];
      dtemp_2_r <= dtemp_2_nxt;
      low_2_r   <= q6[18];
    end
    if (en[3]) begin
      d1_3_r    <= d1_2_r;
      temp_3_r  <= temp_3_nxt;
      off1_3_r  <= off1_2_r;
      sens1_3_r <= sens1_2_r;
      aux5_3_r  <= aux5_3_nxt;
      low_3_r   <= low_2_r;
    end
    if (en[4]) begin
      d1_4_r   <= d1_3_r;
      temp_4_r <= temp_4_nxt;
      off_4_r  <= off_4_nxt;
      sens_4_r <= sens_4_nxt;
    end
    if (en[5]) begin
      temp_5_r <= temp_4_r;
      off_5_r  <= off_4_r;
      pl_5_r   <= pl_5_nxt;
      ph_5_r   <= ph_5_nxt;
    end
    if (en[6]) begin
      temp_6_r <= temp_5_r;
      off_6_r  <= off_5_r;
      prod_6_r <= prod_6_nxt;
    end
    if (en[7]) begin
      temp_7_r <= temp_6_r;
      off_7_r  <= off_6_r;
      q_7_r    <= prodb[63:21];
    end
    if (en[8]) begin
      temp_8_r <= temp_7_r;
      b_8_r    <= b_8_nxt;
    end
    if (en[9]) begin
      temp_9_r <= temp_8_r;
      pres_9_r <= pres_9_nxt;
    end
  end

  // An empty output stage means every stage can move, so the input must be open.
  `CHK_IMPLY(a_ready_when_drained, !vld_r[NS-1], in_tready, "input held off with output empty")
  // The input is only held off when every stage holds a word.
  `CHK_IMPLY(a_stall_only_full, in_tvalid && !in_tready, &vld_r, "input stalled with a free stage")
  // Second-order terms exist only below 20.00 C.
  `CHK_IMPLY(a_aux_only_low, vld_r[3] && !low_3_r, aux5_3_r == '0, "second-order term above 20 C")

endmodule
